// File: rtl/osl_pkg.sv
package osl_pkg;

   // request modes
   localparam logic [1:0] MODE_OK  = 2'd0;
   localparam logic [1:0] MODE_ERR = 2'd1;
   localparam logic [1:0] MODE_POS = 2'd2;

   // ASCII characters of a reply line
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_O     = 8'h6F;
   localparam logic [7:0] CHAR_K     = 8'h6B;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_R     = 8'h72;

   // a 32-bit magnitude spans eleven octal digits
   localparam int OCT_DIGITS = 11;
   localparam int CNT_W      = 4;
   localparam int MAG_W      = 3 * OCT_DIGITS;

   typedef enum logic [1:0] {
      NUM_ERR,
      NUM_TID,
      NUM_X,
      NUM_Y
   } num_sel_type;

   typedef enum logic [3:0] {
      CH_O,
      CH_K,
      CH_E,
      CH_R,
      CH_MINUS,
      CH_DIGIT,
      CH_SPACE,
      CH_CR,
      CH_LF
   } char_sel_type;

   typedef struct packed {
      logic         capture;
      logic         load;
      num_sel_type  num_sel;
      logic         shift;
      logic         emit;
      char_sel_type char_sel;
      logic         last;
   } osl_cmd_type;

   typedef struct packed {
      logic neg;
      logic top_zero;
      logic count_one;
   } osl_status_type;

endpackage

// File: rtl/osl_datapath.sv
module osl_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  osl_pkg::osl_cmd_type  cmd,
   output osl_pkg::osl_status_type status,
   input  logic signed [15:0]    req_error_code,
   input  logic [7:0]            req_target_id,
   input  logic signed [31:0]    req_pos_x,
   input  logic signed [31:0]    req_pos_y,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_char_out,
   output logic                  rsp_last
);

   logic [15:0] err_ff;
   logic [7:0]  tid_ff;
   logic [31:0] x_ff;
   logic [31:0] y_ff;

   logic [osl_pkg::MAG_W-1:0] mag_ff;
   logic [osl_pkg::CNT_W-1:0] cnt_ff;
   logic                      neg_ff;

   logic       rsp_valid_ff;
   logic [7:0] rsp_char_ff;
   logic       rsp_last_ff;

   logic [31:0] raw;
   logic [31:0] abs_val;
   logic [7:0]  char_in;

   always_comb begin
      case (cmd.num_sel)
         osl_pkg::NUM_ERR: raw = {{16{err_ff[15]}}, err_ff};
         osl_pkg::NUM_TID: raw = {24'd0, tid_ff};
         osl_pkg::NUM_X:   raw = x_ff;
         default:          raw = y_ff;
      endcase
      // the most negative value wraps to its own unsigned magnitude
      abs_val = raw[31] ? (~raw + 32'd1) : raw;
   end

   always_comb begin
      case (cmd.char_sel)
         osl_pkg::CH_O:     char_in = osl_pkg::CHAR_O;
         osl_pkg::CH_K:     char_in = osl_pkg::CHAR_K;
         osl_pkg::CH_E:     char_in = osl_pkg::CHAR_E;
         osl_pkg::CH_R:     char_in = osl_pkg::CHAR_R;
         osl_pkg::CH_MINUS: char_in = osl_pkg::CHAR_MINUS;
         osl_pkg::CH_DIGIT:
            char_in = osl_pkg::CHAR_ZERO + {5'd0, mag_ff[osl_pkg::MAG_W-1 -: 3]};
         osl_pkg::CH_SPACE: char_in = osl_pkg::CHAR_SPACE;
         osl_pkg::CH_CR:    char_in = osl_pkg::CHAR_CR;
         default:           char_in = osl_pkg::CHAR_LF;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         err_ff <= req_error_code;
         tid_ff <= req_target_id;
         x_ff   <= req_pos_x;
         y_ff   <= req_pos_y;
      end
      if (cmd.load) begin
         mag_ff <= {1'b0, abs_val};
         neg_ff <= raw[31];
         cnt_ff <= osl_pkg::CNT_W'(osl_pkg::OCT_DIGITS);
      end else if (cmd.shift) begin
         // advance to the next octal digit
         mag_ff <= {mag_ff[osl_pkg::MAG_W-4:0], 3'd0};
         cnt_ff <= cnt_ff - osl_pkg::CNT_W'(1);
      end
      rsp_char_ff <= char_in;
      rsp_last_ff <= cmd.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign status.neg       = neg_ff;
   assign status.top_zero  = (mag_ff[osl_pkg::MAG_W-1 -: 3] == 3'd0);
   assign status.count_one = (cnt_ff == osl_pkg::CNT_W'(1));

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: rtl/osl_controller.sv
module osl_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_mode,
   output logic                   busy,
   output osl_pkg::osl_cmd_type   cmd,
   input  osl_pkg::osl_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OK_O,
      ST_OK_K,
      ST_ERR_E,
      ST_ERR_R1,
      ST_ERR_R2,
      ST_LOAD,
      ST_SIGN,
      ST_SKIP,
      ST_DIGIT,
      ST_SPACE,
      ST_CR,
      ST_LF
   } state_type;

   state_type             state_ff, state_in;
   osl_pkg::num_sel_type  num_sel_ff, num_sel_in;

   always_comb begin
      state_in     = state_ff;
      num_sel_in   = num_sel_ff;
      cmd          = '0;
      cmd.num_sel  = num_sel_ff;
      cmd.char_sel = osl_pkg::CH_LF;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
            if (start) begin
               case (req_mode)
                  osl_pkg::MODE_OK:  state_in = ST_OK_O;
                  osl_pkg::MODE_ERR: begin
                     state_in   = ST_ERR_E;
                     num_sel_in = osl_pkg::NUM_ERR;
                  end
                  osl_pkg::MODE_POS: begin
                     state_in   = ST_LOAD;
                     num_sel_in = osl_pkg::NUM_TID;
                  end
                  // unused mode: drop the request
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_OK_O: begin
            cmd.emit = 1'b1; cmd.char_sel = osl_pkg::CH_O; state_in = ST_OK_K;
         end
         ST_OK_K: begin
            cmd.emit = 1'b1; cmd.char_sel = osl_pkg::CH_K; state_in = ST_CR;
         end
         ST_ERR_E: begin
            cmd.emit = 1'b1; cmd.char_sel = osl_pkg::CH_E; state_in = ST_ERR_R1;
         end
         ST_ERR_R1: begin
            cmd.emit = 1'b1; cmd.char_sel = osl_pkg::CH_R; state_in = ST_ERR_R2;
         end
         ST_ERR_R2: begin
            cmd.emit = 1'b1; cmd.char_sel = osl_pkg::CH_R; state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            cmd.emit     = status.neg;
            cmd.char_sel = osl_pkg::CH_MINUS;
            state_in     = ST_SKIP;
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (status.top_zero && !status.count_one) begin
               cmd.shift = 1'b1;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            cmd.emit     = 1'b1;
            cmd.shift    = 1'b1;
            cmd.char_sel = osl_pkg::CH_DIGIT;
            if (status.count_one) begin
               if (num_sel_ff == osl_pkg::NUM_TID || num_sel_ff == osl_pkg::NUM_X) begin
                  state_in = ST_SPACE;
               end else begin
                  state_in = ST_CR;
               end
            end
         end
         ST_SPACE: begin
            cmd.emit     = 1'b1;
            cmd.char_sel = osl_pkg::CH_SPACE;
            num_sel_in   = (num_sel_ff == osl_pkg::NUM_TID) ? osl_pkg::NUM_X
                                                            : osl_pkg::NUM_Y;
            state_in     = ST_LOAD;
         end
         ST_CR: begin
            cmd.emit = 1'b1; cmd.char_sel = osl_pkg::CH_CR; state_in = ST_LF;
         end
         ST_LF: begin
            cmd.emit     = 1'b1;
            cmd.char_sel = osl_pkg::CH_LF;
            cmd.last     = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         num_sel_ff <= osl_pkg::NUM_ERR;
      end else begin
         state_ff   <= state_in;
         num_sel_ff <= num_sel_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: rtl/octal_status_line_formatter_unit.sv
// Formats one status request into an ASCII reply line, one character per beat on
// rsp_char_out with rsp_valid high for one cycle; rsp_last marks the closing line
// feed. The receiver cannot stall, so it must take a beat in every cycle that
// rsp_valid is high. A request is taken when start is high and busy is low; mode 3
// is taken and produces no beat. Each number is scanned over all eleven octal
// positions of a 32-bit value: the load and sign states come first, then the scan
// state drops each leading zero and exits to the digit state, which emits the
// remaining digits; the sign state is passed whether or not the number carries a
// minus sign. Characters of one line may be spaced apart by these states.
module octal_status_line_formatter_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_error_code,
   input  logic [7:0]         req_target_id,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   output logic               rsp_valid,
   output logic [7:0]         rsp_char_out,
   output logic               rsp_last
);

   osl_pkg::osl_cmd_type    cmd;
   osl_pkg::osl_status_type status;

   osl_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .busy     (busy),
      .cmd      (cmd),
      .status   (status)
   );

   osl_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_error_code (req_error_code),
      .req_target_id  (req_target_id),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .rsp_valid      (rsp_valid),
      .rsp_char_out   (rsp_char_out),
      .rsp_last       (rsp_last)
   );

endmodule
